FILE: hw/rtl/line_rasterizer_slope_intercept_macros.svh
// assertion macros for the line rasterizer
// used by the modules that carry concurrent checks; expects clk and rst_n in scope
`ifndef LINE_RASTERIZER_SLOPE_INTERCEPT_MACROS_SVH
`define LINE_RASTERIZER_SLOPE_INTERCEPT_MACROS_SVH

// same-cycle implication
`define LRSI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrsi check failed");

// next-cycle implication
`define LRSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrsi check failed");

`endif

FILE: hw/rtl/lrsi_pkg.sv
// shared constants, widths and controller/datapath interface types
// no dependencies
package lrsi_pkg;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_W      = COORD_BITS + FRAC_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int NUM_W      = COORD_BITS + FRAC_BITS + 1;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int RAT_W      = FRAC_BITS + 2;
    localparam int PROD_W     = DIFF_W + RAT_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int CNT_W      = $clog2(FRAC_BITS + 1);
    localparam int REG_IDX_W  = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = ((2 * OUT_W + 7) / 8) * 8;

    localparam logic [REG_IDX_W-1:0] REG_START_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_END_X   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_END_Y   = 2'd3;

    typedef struct packed {
        logic latch;
        logic div_step;
        logic div_last;
        logic load_first;
        logic load_second;
        logic load_sweep;
        logic advance;
    } lrsi_cmd_t;

    typedef struct packed {
        logic sweep_end;
    } lrsi_stat_t;

endpackage

FILE: hw/rtl/line_rasterizer_slope_intercept.sv
// line rasterizer, slope-intercept form: top level
// depends on lrsi_pkg, lrsi_ctrl and lrsi_dp
//
// usage:
// - endpoints are written through cfg_we/cfg_index/cfg_data (0 start_x, 1 start_y,
//   2 end_x, 3 end_y), signed integer pixels, while the block is idle
// - an input item with restart=1 latches the line and starts the slope ratio
//   division; it yields no point. the divider is restoring, one quotient bit per
//   cycle, and s_tready is low while it runs
// - each input item with restart=0 then yields one point item on the master side:
//   start endpoint, end endpoint, then one point per major-axis step; m_tlast
//   marks the final point, later items yield nothing
// - m_tvalid rises in the cycle after input accept; one item per cycle after the
//   divider finishes while the receiver takes them, with a single multiply-add stage
// - a stalled receiver holds the output register and s_tready drops until it
//   is taken, so nothing is lost or repeated
// - after reset: endpoints zero, no line active, output empty
module line_rasterizer_slope_intercept
    import lrsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // restart, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // point_x, point_y, zero fill
    output logic                  m_tlast    // last_point
);

    lrsi_cmd_t        cmd;
    lrsi_stat_t       stat;
    logic [OUT_W-1:0] point_x, point_y;

    lrsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .restart   (s_tdata[0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lrsi_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({point_y, point_x});

endmodule

FILE: hw/rtl/lrsi_ctrl.sv
// controller: line phase state machine, divider step counter, output valid
// depends on lrsi_pkg and the assertion macro header
`include "line_rasterizer_slope_intercept_macros.svh"

module lrsi_ctrl
    import lrsi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       restart,
    output logic       out_valid,
    input  logic       out_ready,
    input  lrsi_stat_t stat,
    output lrsi_cmd_t  cmd
);

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_FIRST  = 3'd2;
    localparam logic [2:0] ST_SECOND = 3'd3;
    localparam logic [2:0] ST_SWEEP  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic             accept, tick, emit;

    assign in_ready = (state_reg != ST_DIV) && (!valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign tick     = accept && !restart;

    always_comb
    begin
        cmd             = '0;
        cmd.latch       = accept && restart;
        cmd.div_step    = (state_reg == ST_DIV);
        cmd.div_last    = (state_reg == ST_DIV) && (cnt_reg == '0);
        cmd.load_first  = tick && (state_reg == ST_FIRST);
        cmd.load_second = tick && (state_reg == ST_SECOND);
        cmd.load_sweep  = tick && (state_reg == ST_SWEEP);
        cmd.advance     = cmd.load_sweep && !stat.sweep_end;
    end

    assign emit       = cmd.load_first || cmd.load_second || cmd.load_sweep;
    assign valid_next = emit || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        priority if (accept && restart)
        begin
            state_next = ST_DIV;
            cnt_next   = CNT_W'(FRAC_BITS);
        end
        else
        begin
            unique case (state_reg)
                ST_DIV:
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_FIRST;
                    end
                end
                ST_FIRST:
                begin
                    if (tick)
                    begin
                        state_next = ST_SECOND;
                    end
                end
                ST_SECOND:
                begin
                    if (tick)
                    begin
                        state_next = ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    if (tick && stat.sweep_end)
                    begin
                        state_next = ST_DONE;
                    end
                end
                default:
                begin
                    state_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DONE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    `LRSI_ASSERT_NOW(a_div_blocks_input, state_reg == ST_DIV, !in_ready)
    `LRSI_ASSERT_NEXT(a_restart_divides, accept && restart, state_reg == ST_DIV)
    `LRSI_ASSERT_NEXT(a_emit_shows_item, emit, valid_reg)
    `LRSI_ASSERT_NOW(a_stall_holds_payload, valid_reg && !out_ready, !emit)

endmodule

FILE: hw/rtl/lrsi_dp.sv
// datapath: endpoint registers, line setup, restoring ratio divider,
// sweep point multiply-add with saturation, output payload registers
// depends on lrsi_pkg
module lrsi_dp
    import lrsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  lrsi_cmd_t            cmd,
    output lrsi_stat_t           stat,
    output logic [OUT_W-1:0]     point_x,
    output logic [OUT_W-1:0]     point_y,
    output logic                 last_point
);

    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [COORD_BITS-1:0] idx_reg, idx_next, end_reg;
    logic signed [RAT_W-1:0]      ratio_reg;
    logic                         steep_reg;
    logic                         neg_reg, zero_reg;
    logic [NUM_W-1:0]             rem_reg, dvs_reg;
    logic [QUO_W-1:0]             quo_reg, quo_next;
    logic [OUT_W-1:0]             px_reg, py_reg;
    logic                         last_reg;

    // line setup
    logic signed [DIFF_W-1:0]     dx, dy, dmaj, dmin;
    logic [DIFF_W-1:0]            adx, ady, amaj_w, amin_w;
    logic [COORD_BITS-1:0]        amaj, amin;
    logic                         steep;
    logic signed [COORD_BITS-1:0] a_maj, b_maj;
    logic [NUM_W-1:0]             num;

    // divider step
    logic                         fits;
    logic [NUM_W-1:0]             rem_next;
    logic signed [RAT_W-1:0]      ratio_next;

    // sweep point
    logic signed [COORD_BITS-1:0] base_maj, base_min;
    logic signed [DIFF_W-1:0]     rel;
    logic signed [PROD_W-1:0]     prod;
    logic signed [SUM_W-1:0]      sum;
    logic [OUT_W-1:0]             mnr_sat, maj_fx;
    logic                         in_range;

    always_comb
    begin
        dx     = DIFF_W'(ex_reg) - DIFF_W'(sx_reg);
        dy     = DIFF_W'(ey_reg) - DIFF_W'(sy_reg);
        adx    = dx[DIFF_W-1] ? -dx : dx;
        ady    = dy[DIFF_W-1] ? -dy : dy;
        steep  = ady > adx;
        dmaj   = steep ? dy : dx;
        dmin   = steep ? dx : dy;
        a_maj  = steep ? sy_reg : sx_reg;
        b_maj  = steep ? ey_reg : ex_reg;
        amaj_w = dmaj[DIFF_W-1] ? -dmaj : dmaj;
        amin_w = dmin[DIFF_W-1] ? -dmin : dmin;
        amaj   = amaj_w[COORD_BITS-1:0];
        amin   = amin_w[COORD_BITS-1:0];
        num    = NUM_W'({amin, {FRAC_BITS{1'b0}}}) + NUM_W'(amaj >> 1);
    end

    always_comb
    begin
        fits       = rem_reg >= dvs_reg;
        rem_next   = fits ? (rem_reg - dvs_reg) : rem_reg;
        quo_next   = {quo_reg[QUO_W-2:0], fits};
        ratio_next = neg_reg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
    end

    always_comb
    begin
        base_maj = steep_reg ? sy_reg : sx_reg;
        base_min = steep_reg ? sx_reg : sy_reg;
        rel      = DIFF_W'(idx_reg) - DIFF_W'(base_maj);
        prod     = PROD_W'(rel) * PROD_W'(ratio_reg);
        sum      = SUM_W'($signed({base_min, {FRAC_BITS{1'b0}}})) + SUM_W'(prod);
        in_range = (sum[SUM_W-1:OUT_W-1] == '0) || (sum[SUM_W-1:OUT_W-1] == '1);
        if (in_range)
        begin
            mnr_sat = sum[OUT_W-1:0];
        end
        else
        begin
            mnr_sat = {sum[SUM_W-1], {(OUT_W-1){~sum[SUM_W-1]}}};
        end
        maj_fx   = {idx_reg, {FRAC_BITS{1'b0}}};
        idx_next = idx_reg + 1'b1;
    end

    assign stat.sweep_end = idx_reg >= end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg    <= '0;
            sy_reg    <= '0;
            ex_reg    <= '0;
            ey_reg    <= '0;
            idx_reg   <= '0;
            end_reg   <= '0;
            ratio_reg <= '0;
            steep_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_X: sx_reg <= cfg_data;
                    REG_START_Y: sy_reg <= cfg_data;
                    REG_END_X:   ex_reg <= cfg_data;
                    REG_END_Y:   ey_reg <= cfg_data;
                    default:     sx_reg <= sx_reg;
                endcase
            end
            if (cmd.latch)
            begin
                steep_reg <= steep;
                idx_reg   <= (a_maj < b_maj) ? a_maj : b_maj;
                end_reg   <= (a_maj < b_maj) ? b_maj : a_maj;
            end
            else if (cmd.advance)
            begin
                idx_reg <= idx_next;
            end
            if (cmd.div_last)
            begin
                ratio_reg <= zero_reg ? '0 : ratio_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            rem_reg  <= num;
            dvs_reg  <= NUM_W'({amaj, {FRAC_BITS{1'b0}}});
            quo_reg  <= '0;
            neg_reg  <= dmin[DIFF_W-1] ^ dmaj[DIFF_W-1];
            zero_reg <= (amaj == '0);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= quo_next;
        end
        if (cmd.load_first)
        begin
            px_reg   <= {sx_reg, {FRAC_BITS{1'b0}}};
            py_reg   <= {sy_reg, {FRAC_BITS{1'b0}}};
            last_reg <= 1'b0;
        end
        else if (cmd.load_second)
        begin
            px_reg   <= {ex_reg, {FRAC_BITS{1'b0}}};
            py_reg   <= {ey_reg, {FRAC_BITS{1'b0}}};
            last_reg <= 1'b0;
        end
        else if (cmd.load_sweep)
        begin
            px_reg   <= steep_reg ? mnr_sat : maj_fx;
            py_reg   <= steep_reg ? maj_fx : mnr_sat;
            last_reg <= stat.sweep_end;
        end
    end

    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign last_point = last_reg;

endmodule

FILE: dv/line_rasterizer_slope_intercept_test.sv
// testbench for line_rasterizer_slope_intercept: streams restart and next-point items
// through the slave side and checks every point against a built-in predictor
// depends on lrsi_pkg and the line_rasterizer_slope_intercept rtl
module line_rasterizer_slope_intercept_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lrsi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;

    typedef enum logic [1:0] {LINE_IDLE, LINE_FIRST, LINE_SECOND, LINE_SWEEP} line_phase_e;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    last;
    } point_t;

    class point_scoreboard;
        int          coord[4];
        line_phase_e phase;
        int          major_index;
        int          major_end;
        int          ratio;
        bit          steep;
        point_t      expected_q[$];
        int          errors;
        int          useful_items;

        function new();
            foreach (coord[i]) coord[i] = 0;
            phase        = LINE_IDLE;
            major_index  = 0;
            major_end    = 0;
            ratio        = 0;
            steep        = 0;
            errors       = 0;
            useful_items = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic signed [COORD_BITS-1:0] val);
            coord[idx] = val;
        endfunction

        function int iabs(int v);
            return (v < 0) ? -v : v;
        endfunction

        function logic signed [OUT_W-1:0] clamp_point(int v);
            int hi;
            int lo;
            hi = (1 << (OUT_W - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v[OUT_W-1:0];
        endfunction

        function void start_line();
            int dx, dy, dmaj, dmin, a, b, n, d, q;
            dx = coord[REG_END_X] - coord[REG_START_X];
            dy = coord[REG_END_Y] - coord[REG_START_Y];
            steep = iabs(dy) > iabs(dx);
            if (steep)
            begin
                dmaj = dy;
                dmin = dx;
                a    = coord[REG_START_Y];
                b    = coord[REG_END_Y];
            end
            else
            begin
                dmaj = dx;
                dmin = dy;
                a    = coord[REG_START_X];
                b    = coord[REG_END_X];
            end
            if (dmaj == 0)
                ratio = 0;
            else
            begin
                n     = iabs(dmin) << FRAC_BITS;
                d     = iabs(dmaj);
                q     = (n + d / 2) / d;
                ratio = ((dmin < 0) != (dmaj < 0)) ? -q : q;
            end
            major_index = (a < b) ? a : b;
            major_end   = (a < b) ? b : a;
            phase       = LINE_FIRST;
        endfunction

        function void note_input(bit restart);
            point_t p;
            int     one, base_maj, base_min, mnr;
            one = 1 << FRAC_BITS;
            useful_items++;
            if (restart)
            begin
                start_line();
                return;
            end
            if (phase == LINE_IDLE)
                return;
            p.last = 1'b0;
            case (phase)
                LINE_FIRST:
                begin
                    p.x   = clamp_point(coord[REG_START_X] * one);
                    p.y   = clamp_point(coord[REG_START_Y] * one);
                    phase = LINE_SECOND;
                end
                LINE_SECOND:
                begin
                    p.x   = clamp_point(coord[REG_END_X] * one);
                    p.y   = clamp_point(coord[REG_END_Y] * one);
                    phase = LINE_SWEEP;
                end
                default:
                begin
                    base_maj = steep ? coord[REG_START_Y] : coord[REG_START_X];
                    base_min = steep ? coord[REG_START_X] : coord[REG_START_Y];
                    mnr      = base_min * one + (major_index - base_maj) * ratio;
                    if (steep)
                    begin
                        p.x = clamp_point(mnr);
                        p.y = clamp_point(major_index * one);
                    end
                    else
                    begin
                        p.x = clamp_point(major_index * one);
                        p.y = clamp_point(mnr);
                    end
                    if (major_index >= major_end)
                    begin
                        p.last = 1'b1;
                        phase  = LINE_IDLE;
                    end
                    else
                        major_index++;
                end
            endcase
            expected_q.push_back(p);
        endfunction

        function void check_point(logic [M_TDATA_W-1:0] data, logic last);
            point_t                  want;
            logic signed [OUT_W-1:0] got_x;
            logic signed [OUT_W-1:0] got_y;
            got_x = data[OUT_W-1:0];
            got_y = data[2*OUT_W-1:OUT_W];
            if (expected_q.size() == 0)
            begin
                $error("unexpected point item: x %0d y %0d last %0b", got_x, got_y, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got_x !== want.x)
            begin
                $error("point_x mismatch: expected %0d, got %0d", want.x, got_x);
                errors++;
            end
            if (got_y !== want.y)
            begin
                $error("point_y mismatch: expected %0d, got %0d", want.y, got_y);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_point mismatch: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [COORD_BITS-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // restart, zero fill
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // point_x, point_y, zero fill
    logic                  m_tlast;    // last_point

    point_scoreboard sb;
    int              line_coord[4];
    bit              source_gaps = 1'b0;
    bit              sink_gaps = 1'b0;
    int unsigned     cycle_count = 0;

    line_rasterizer_slope_intercept u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (m_tvalid && m_tready)
                sb.check_point(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata[0]);
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("line_rasterizer_slope_intercept_test: done, errors");
        $finish;
    end

    task automatic send_item(bit restart);
        if (source_gaps && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, restart};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic hold_off();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    // the divider may still run after a restart that left nothing pending
    task automatic settle();
        hold_off();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_we          <= 1'b1;
        cfg_index       <= idx;
        cfg_data        <= val[COORD_BITS-1:0];
        line_coord[idx]  = val;
        @(negedge clk);
        cfg_we          <= 1'b0;
    endtask

    task automatic set_line(int x1, int y1, int x2, int y2);
        write_reg(REG_START_X, x1);
        write_reg(REG_START_Y, y1);
        write_reg(REG_END_X, x2);
        write_reg(REG_END_Y, y2);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 7))
            0:       return -1024;
            1:       return 1023;
            default: return int'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    function automatic int near_coord(int c);
        int v;
        v = c + int'($urandom_range(0, 24)) - 12;
        if (v > 1023) v = 1023;
        if (v < -1024) v = -1024;
        return v;
    endfunction

    function automatic int line_points();
        int dx, dy;
        dx = line_coord[REG_END_X] - line_coord[REG_START_X];
        dy = line_coord[REG_END_Y] - line_coord[REG_START_Y];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return ((dx > dy) ? dx : dy) + 3;
    endfunction

    task automatic run_directed();
        // no line active yet
        send_item(1'b0);
        hold_off();
        // vertical line
        set_line(5, -3, 5, 2);
        send_item(1'b1);
        repeat (4) send_item(1'b0);
        settle();
        // single point, then a tick past its end
        set_line(7, 7, 7, 7);
        send_item(1'b1);
        repeat (4) send_item(1'b0);
        settle();
        // minor axis rounds past the top of the output range
        set_line(1023, 1019, -1024, 1023);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        settle();
        // and past the bottom
        set_line(1023, -1019, -1024, -1023);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        settle();
        // full diagonal, abandoned by a restart
        set_line(-1024, -1024, 1023, 1023);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        settle();
        // endpoint moved while the line is active
        write_reg(REG_START_X, -1000);
        repeat (2) send_item(1'b0);
    endtask

    task automatic run_random();
        int x1, y1, x2, y2, n, r, k, pause_at;
        bit big;
        while (sb.useful_items < 800)
        begin
            settle();
            source_gaps = (sb.useful_items < 700) && ($urandom_range(0, 2) != 0);
            sink_gaps   = (sb.useful_items < 700) && ($urandom_range(0, 2) != 0);
            big = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(0, 3);
                write_reg(k[REG_IDX_W-1:0], near_coord(line_coord[k]));
            end
            else
            begin
                x1 = rand_coord();
                y1 = rand_coord();
                x2 = big ? rand_coord() : near_coord(x1);
                y2 = big ? rand_coord() : near_coord(y1);
                case ($urandom_range(0, 11))
                    0: x2 = x1;
                    1:
                    begin
                        x2 = x1;
                        y2 = y1;
                    end
                    2: y2 = y1;
                    default: ;
                endcase
                set_line(x1, y1, x2, y2);
            end
            r = $urandom_range(0, 19);
            if (r < 14)
            begin
                send_item(1'b1);
                n = line_points() + $urandom_range(0, 2);
                if (n > 40 && (sb.useful_items + n > 800 || $urandom_range(0, 5) != 0))
                    n = $urandom_range(3, 40);
                pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
                for (k = 0; k < n; k++)
                begin
                    if (k == pause_at)
                        hold_off();
                    send_item(1'b0);
                end
            end
            else if (r < 17)
                repeat ($urandom_range(1, 8)) send_item(1'b0);
            else
                repeat ($urandom_range(1, 8)) send_item($urandom_range(0, 1));
        end
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
    endtask

    initial
    begin
        sb        = new();
        foreach (line_coord[i]) line_coord[i] = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        hold_off();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("line_rasterizer_slope_intercept_test: done, clean");
        else
            $display("line_rasterizer_slope_intercept_test: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/lrsi_pkg.sv
hw/rtl/lrsi_ctrl.sv
hw/rtl/lrsi_dp.sv
hw/rtl/line_rasterizer_slope_intercept.sv
dv/line_rasterizer_slope_intercept_test.sv
